@@ sv/e2q_pkg.sv @@
// e2q_pkg: shared types and constants for the euler_to_quaternion block.
// Holds payload structs, CORDIC arctangent table and fixed-point constants.
// No dependencies.
package e2q_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int PHASE_W        = 32;
    // x/y carry Q30 values with some CORDIC headroom
    localparam int XY_W           = 33;
    localparam int TRIG_W         = 18;
    localparam int PAIR_W         = 2 * TRIG_W;
    localparam int PROD_W         = 3 * TRIG_W;
    localparam int SUM_W          = PROD_W + 1;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam logic signed [15:0] Q14_NEG_ONE = -16'sd16384;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } t_e2q_in;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_e2q_out;

    function automatic logic signed [PHASE_W-1:0] atan_turn(input logic [3:0] idx);
        logic signed [PHASE_W-1:0] v;
        case (idx)
            4'd0:  v = 32'sd536870912;
            4'd1:  v = 32'sd316933406;
            4'd2:  v = 32'sd167458907;
            4'd3:  v = 32'sd85004756;
            4'd4:  v = 32'sd42667331;
            4'd5:  v = 32'sd21354465;
            4'd6:  v = 32'sd10679838;
            4'd7:  v = 32'sd5340245;
            4'd8:  v = 32'sd2670163;
            4'd9:  v = 32'sd1335087;
            4'd10: v = 32'sd667544;
            4'd11: v = 32'sd333772;
            4'd12: v = 32'sd166886;
            4'd13: v = 32'sd83443;
            4'd14: v = 32'sd41721;
            4'd15: v = 32'sd20860;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/euler_to_quaternion.sv @@
// euler_to_quaternion: top level, ZYX Euler angles to Q1.14 unit quaternion.
// Uses e2q_pkg for payload structs, the arctangent table and constants.
//
// Usage:
//   Input channel i_valid/o_ready carries roll, pitch and yaw as signed binary
//   angles (full range = -pi..pi). Output channel o_valid/i_ready carries
//   w, x, y, z in signed Q1.14, saturated to +-1.
//   The pipeline has 21 register stages: one to form the half-angle phases,
//   16 CORDIC stages (one rotation per stage, three angles in parallel
//   lanes), rounding to Q15, a pair-product stage, a triple-product stage
//   and a sum/round/saturate stage.
//   Throughput is one beat per cycle while i_ready is high; a stage advances
//   whenever it is empty or the stage after it advances.
//   Under a receiver stall full stages hold and empty stages can still fill;
//   o_ready drops only when the output beat is stuck and every stage is full.
//   Reset (synchronous, active low) clears all valid bits; payload registers
//   are not reset.
//   No state survives an item: each input beat gives exactly one output beat.
module euler_to_quaternion
    import e2q_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_e2q_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_e2q_out o_data
);

    localparam int NST = CORDIC_STEPS + 5;  // total stages incl. output
    localparam int IDX_W = $clog2(NST);

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;

    // stage advances if downstream one advances or is empty
    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end
    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: half-angle phase ----------------
    function automatic logic signed [PHASE_W-1:0] half_phase(input logic [ANGLE_BITS-1:0] raw);
        logic [ANGLE_BITS-1:0] a;
        logic [ANGLE_BITS-1:0] b;
        logic [PHASE_W+ANGLE_BITS-1:0] wide;
        a = raw;
        b = a ^ (ANGLE_BITS'(1) << (ANGLE_BITS - 1));
        wide = (PHASE_W+ANGLE_BITS)'(b) << 31;
        return PHASE_W'(wide >> ANGLE_BITS) - (PHASE_W'(1) << 30);
    endfunction

    logic signed [PHASE_W-1:0] r_z [0:CORDIC_STEPS][3];
    logic signed [XY_W-1:0]    r_x [0:CORDIC_STEPS][3];
    logic signed [XY_W-1:0]    r_y [0:CORDIC_STEPS][3];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_z[0][0] <= half_phase(i_data.roll_angle);
            r_z[0][1] <= half_phase(i_data.pitch_angle);
            r_z[0][2] <= half_phase(i_data.yaw_angle);
            for (int l = 0; l < 3; l++) begin
                r_x[0][l] <= CORDIC_GAIN;
                r_y[0][l] <= '0;
            end
        end
    end

    // ---------------- stages 1..16: CORDIC rotations ----------------
    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
        for (genvar l = 0; l < 3; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (w_adv[s+1]) begin
                    if (!r_z[s][l][PHASE_W-1]) begin
                        r_x[s+1][l] <= r_x[s][l] - (r_y[s][l] >>> s);
                        r_y[s+1][l] <= r_y[s][l] + (r_x[s][l] >>> s);
                        r_z[s+1][l] <= r_z[s][l] - atan_turn(4'(s));
                    end else begin
                        r_x[s+1][l] <= r_x[s][l] + (r_y[s][l] >>> s);
                        r_y[s+1][l] <= r_y[s][l] - (r_x[s][l] >>> s);
                        r_z[s+1][l] <= r_z[s][l] + atan_turn(4'(s));
                    end
                end
            end
        end
    end

    // ---------------- stage 17: round to Q15 ----------------
    localparam int SR = CORDIC_STEPS + 1;
    logic signed [TRIG_W-1:0] r_c [3];
    logic signed [TRIG_W-1:0] r_s [3];
    always_ff @(posedge i_clk) begin
        if (w_adv[SR]) begin
            for (int l = 0; l < 3; l++) begin
                r_c[l] <= TRIG_W'((r_x[CORDIC_STEPS][l] + XY_W'(1 << 14)) >>> 15);
                r_s[l] <= TRIG_W'((r_y[CORDIC_STEPS][l] + XY_W'(1 << 14)) >>> 15);
            end
        end
    end

    // ---------------- stage 18: roll x pitch products ----------------
    // order: cr*cp, sr*sp, sr*cp, cr*sp
    logic signed [PAIR_W-1:0] r_pp [4];
    logic signed [TRIG_W-1:0] r_cy1, r_sy1;
    always_ff @(posedge i_clk) begin
        if (w_adv[SR+1]) begin
            r_pp[0] <= PAIR_W'(r_c[0]) * PAIR_W'(r_c[1]);
            r_pp[1] <= PAIR_W'(r_s[0]) * PAIR_W'(r_s[1]);
            r_pp[2] <= PAIR_W'(r_s[0]) * PAIR_W'(r_c[1]);
            r_pp[3] <= PAIR_W'(r_c[0]) * PAIR_W'(r_s[1]);
            r_cy1   <= r_c[2];
            r_sy1   <= r_s[2];
        end
    end

    // ---------------- stage 19: times yaw terms ----------------
    logic signed [PROD_W-1:0] r_t [8];
    always_ff @(posedge i_clk) begin
        if (w_adv[SR+2]) begin
            for (int p = 0; p < 4; p++) begin
                r_t[2*p]   <= PROD_W'(r_pp[p]) * PROD_W'(r_cy1);
                r_t[2*p+1] <= PROD_W'(r_pp[p]) * PROD_W'(r_sy1);
            end
        end
    end

    // ---------------- stage 20: sum, round, saturate ----------------
    function automatic logic signed [15:0] to_q14(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = (v + SUM_W'(64'sd1 << 30)) >>> 31;
        if (r > SUM_W'(Q14_ONE)) begin
            return Q14_ONE;
        end else if (r < SUM_W'(Q14_NEG_ONE)) begin
            return Q14_NEG_ONE;
        end
        return 16'(r);
    endfunction

    // t index: 2p = pair p * cy, 2p+1 = pair p * sy
    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) begin
            o_data.quat_w <= to_q14(SUM_W'(r_t[0]) + SUM_W'(r_t[3]));
            o_data.quat_x <= to_q14(SUM_W'(r_t[4]) - SUM_W'(r_t[7]));
            o_data.quat_y <= to_q14(SUM_W'(r_t[6]) + SUM_W'(r_t[5]));
            o_data.quat_z <= to_q14(SUM_W'(r_t[1]) - SUM_W'(r_t[2]));
        end
    end

    // ---------------- assertions ----------------
    logic [IDX_W-1:0] w_cnt;
    assign w_cnt = IDX_W'($countones(r_vld));

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_vld == '1)
        else $error("input stalled with empty stage");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.quat_w <= Q14_ONE && o_data.quat_w >= Q14_NEG_ONE)
        else $error("quat_w out of range");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready && !(i_valid && o_ready) |=> w_cnt <= $past(w_cnt))
        else $error("beat invented in pipeline");

endmodule

@@ test/testbench.sv @@
// testbench: checks euler_to_quaternion beat by beat against a CORDIC-based predictor.
// Depends on e2q_pkg (payload structs) and the euler_to_quaternion RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import e2q_pkg::*;

    localparam int ANGLE_W = 16;
    localparam int PIPE_DEPTH = 21;
    localparam int N_RANDOM = 1830;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_e2q_in  i_data = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_e2q_out o_data;

    t_e2q_out quat_queue[$];
    int       n_errors = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    euler_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    localparam longint ATAN_TURNS[16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41721, 20860
    };

    // >>> on longint is an arithmetic floor shift
    function automatic void half_trig(input logic [15:0] raw,
                                      output longint c, output longint s);
        longint px, py, ph, dx, dy;
        logic [15:0] biased;
        px = 652032874;
        py = 0;
        biased = raw ^ 16'h8000;
        ph = ((longint'(biased) << 31) >> ANGLE_W) - (longint'(1) << 30);
        for (int i = 0; i < 16; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (ph >= 0) begin
                px -= dx; py += dy; ph -= ATAN_TURNS[i];
            end else begin
                px += dx; py -= dy; ph += ATAN_TURNS[i];
            end
        end
        c = (px + (longint'(1) << 14)) >>> 15;
        s = (py + (longint'(1) << 14)) >>> 15;
    endfunction

    function automatic logic [15:0] round_sat_q14(input longint v);
        longint r;
        r = (v + (longint'(1) << 30)) >>> 31;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic t_e2q_out zyx_quaternion(input t_e2q_in a);
        longint cr, sr, cp, sp, cy, sy;
        t_e2q_out q;
        half_trig(a.roll_angle, cr, sr);
        half_trig(a.pitch_angle, cp, sp);
        half_trig(a.yaw_angle, cy, sy);
        q.quat_w = round_sat_q14(cr * cp * cy + sr * sp * sy);
        q.quat_x = round_sat_q14(sr * cp * cy - cr * sp * sy);
        q.quat_y = round_sat_q14(cr * sp * cy + sr * cp * sy);
        q.quat_z = round_sat_q14(cr * cp * sy - sr * sp * cy);
        return q;
    endfunction

    // Send one beat; valid stays high across back-to-back beats.
    task automatic send_angles(input t_e2q_in a, input t_e2q_out q);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= a;
        do @(posedge i_clk); while (!o_ready);
        quat_queue.push_back(q);
        n_sent++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_e2q_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (quat_queue.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $realtime, o_data);
                n_errors++;
            end else begin
                want = quat_queue.pop_front();
                n_checked++;
                if (o_data.quat_w !== want.quat_w || o_data.quat_x !== want.quat_x ||
                    o_data.quat_y !== want.quat_y || o_data.quat_z !== want.quat_z) begin
                    $display("%0t: mismatch expected w%0d x%0d y%0d z%0d actual w%0d x%0d y%0d z%0d",
                             $realtime, want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                             o_data.quat_w, o_data.quat_x, o_data.quat_y, o_data.quat_z);
                    n_errors++;
                end
            end
        end
    end

    typedef struct {
        t_e2q_in  angles;
        bit       known;
        t_e2q_out quat;
    } t_angle_row;

    t_angle_row angle_rows[] = '{
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, '0},
        '{'{16'sh7fff, 16'sh0000, 16'sh0000}, 1'b0, '0},
        '{'{16'sh8000, 16'sh0000, 16'sh0000}, 1'b0, '0},
        '{'{16'sh0000, 16'sh7fff, 16'sh0000}, 1'b0, '0},
        '{'{16'sh0000, 16'sh8000, 16'sh0000}, 1'b0, '0},
        '{'{16'sh0000, 16'sh0000, 16'sh7fff}, 1'b0, '0},
        '{'{16'sh0000, 16'sh0000, 16'sh8000}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
        '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
        '{'{16'sh4000, 16'sh0000, 16'sh0000}, 1'b0, '0},
        '{'{16'shc000, 16'sh4000, 16'sh0000}, 1'b0, '0},
        '{'{16'sh0000, 16'shc000, 16'sh4000}, 1'b0, '0},
        '{'{16'sh2000, 16'sh2000, 16'sh2000}, 1'b0, '0},
        '{'{16'shffff, 16'shffff, 16'shffff}, 1'b0, '0},
        '{'{16'sh0001, 16'sh0001, 16'sh0001}, 1'b0, '0},
        '{'{16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, '0},
        '{'{16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, '0},
        '{'{16'sh8000, 16'sh7fff, 16'sh0001}, 1'b0, '0}
    };

    initial begin
        t_e2q_in a;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (angle_rows[k])
            send_angles(angle_rows[k].angles, angle_rows[k].known ? angle_rows[k].quat
                                              : zyx_quaternion(angle_rows[k].angles));
        for (int n = 0; n < N_RANDOM; n++) begin
            case ((n * 5) / N_RANDOM)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                3: begin send_idle_pct = 19; recv_stall_pct = 19; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // hold off until the pipeline has drained
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (quat_queue.size() != 0) @(negedge i_clk);
            end
            a.roll_angle  = 16'($urandom);
            a.pitch_angle = 16'($urandom);
            a.yaw_angle   = 16'($urandom);
            send_angles(a, zyx_quaternion(a));
        end
        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (quat_queue.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);
        $display("covered %0d angle triples (directed extremes, random, idle and stall phases),",
                 n_sent);
        $display("%0d quaternions checked", n_checked);
        if (n_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench: errors");
        $finish;
    end

endmodule
